// ----- rtl/core/lru_block_cache_controller_assert.svh -----
// Assertion macros shared by the block cache controller RTL.
// Defining NO_ASSERTIONS turns every macro into an empty line.
`ifndef LRU_BLOCK_CACHE_CONTROLLER_ASSERT_SVH
`define LRU_BLOCK_CACHE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LBC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LBC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LBC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define LBC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/lbc_pkg.sv -----
// Types, codes and constants of the block cache controller.
// Used by lbc_ctrl, lbc_dpath and lru_block_cache_controller; depends on nothing.
package lbc_pkg;

	localparam int NUM_SLOTS_DEF   = 4;
	localparam int MAX_SECTORS_DEF = 8;
	localparam int BLK_W           = 32;
	localparam int ADDR_W          = 32;
	localparam int STAMP_W         = 32;
	localparam int SPB_W           = 4;
	localparam logic [SPB_W-1:0] SPB_RESET = 4'd2;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_DONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_HIT     = 3'd0,
		STAT_CMD     = 3'd1,
		STAT_FILLED  = 3'd2,
		STAT_ZERO    = 3'd3,
		STAT_IOERR   = 3'd4,
		STAT_WRITTEN = 3'd5,
		STAT_FLUSHED = 3'd6,
		STAT_BUSY    = 3'd7
	} stat_t;

	typedef enum logic [1:0] {
		DCMD_NONE  = 2'd0,
		DCMD_READ  = 2'd1,
		DCMD_WRITE = 2'd2
	} dcmd_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_READ  = 2'd1,
		PEND_WRITE = 2'd2
	} pend_t;

	typedef enum logic [3:0] {
		RESP_HIT,
		RESP_CMD,
		RESP_FILLED,
		RESP_ZERO,
		RESP_ERR_READ,
		RESP_ERR_WRITE,
		RESP_WRITTEN,
		RESP_FLUSHED,
		RESP_BUSY
	} resp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_CHOOSE,
		S_ISSUE,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic  load;
		logic  scan_step;
		logic  issue_read;
		logic  issue_write;
		logic  emit;
		resp_t resp;
	} ctrl_cmd_t;

	typedef struct packed {
		action_t act;
		logic    blk_zero;
		logic    io_err;
		pend_t   pend;
		logic    scan_last;
		logic    hit;
		logic    issue_last;
		logic    out_free;
	} dp_status_t;

endpackage

// ----- rtl/core/lbc_ctrl.sv -----
// Sequencing state machine of the block cache controller.
// Depends on lbc_pkg; drives lbc_dpath through command and status structs.
module lbc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  lbc_pkg::dp_status_t    sts,
	output lbc_pkg::ctrl_cmd_t     cmd
);

	lbc_pkg::ctrl_state_t state_q, state_d;
	lbc_pkg::resp_t       resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::S_IDLE;
			resp_q  <= lbc_pkg::RESP_BUSY;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		resp_d   = resp_q;
		cmd      = '0;
		cmd.resp = resp_q;
		s_tready = 1'b0;
		unique case (state_q)
			lbc_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = lbc_pkg::S_DECODE;
				end
			end
			lbc_pkg::S_DECODE: begin
				priority if (sts.act == lbc_pkg::ACT_DONE) begin
					priority if (sts.pend == lbc_pkg::PEND_READ) begin
						resp_d  = sts.io_err ? lbc_pkg::RESP_ERR_READ : lbc_pkg::RESP_FILLED;
						state_d = lbc_pkg::S_RESP;
					end else if (sts.pend == lbc_pkg::PEND_WRITE) begin
						if (sts.io_err) begin
							resp_d  = lbc_pkg::RESP_ERR_WRITE;
							state_d = lbc_pkg::S_RESP;
						end else begin
							state_d = lbc_pkg::S_SCAN;
						end
					end else begin
						state_d = lbc_pkg::S_IDLE;
					end
				end else if (sts.blk_zero && sts.act != lbc_pkg::ACT_FLUSH) begin
					resp_d  = lbc_pkg::RESP_ZERO;
					state_d = lbc_pkg::S_RESP;
				end else if (sts.pend != lbc_pkg::PEND_NONE) begin
					resp_d  = lbc_pkg::RESP_BUSY;
					state_d = lbc_pkg::S_RESP;
				end else if (sts.act == lbc_pkg::ACT_FLUSH) begin
					resp_d  = lbc_pkg::RESP_FLUSHED;
					state_d = lbc_pkg::S_RESP;
				end else if (sts.act == lbc_pkg::ACT_WRITE) begin
					cmd.issue_write = 1'b1;
					state_d         = lbc_pkg::S_ISSUE;
				end else begin
					state_d = lbc_pkg::S_SCAN;
				end
			end
			lbc_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = lbc_pkg::S_CHOOSE;
				end
			end
			lbc_pkg::S_CHOOSE: begin
				priority if (sts.act == lbc_pkg::ACT_DONE) begin
					resp_d  = lbc_pkg::RESP_WRITTEN;
					state_d = lbc_pkg::S_RESP;
				end else if (sts.hit) begin
					resp_d  = lbc_pkg::RESP_HIT;
					state_d = lbc_pkg::S_RESP;
				end else begin
					cmd.issue_read = 1'b1;
					state_d        = lbc_pkg::S_ISSUE;
				end
			end
			lbc_pkg::S_ISSUE: begin
				cmd.resp = lbc_pkg::RESP_CMD;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.issue_last) begin
						state_d = lbc_pkg::S_IDLE;
					end
				end
			end
			lbc_pkg::S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = lbc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lbc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/lbc_dpath.sv -----
// Datapath of the block cache controller: slot tags and stamps, use counter,
// pending transfer, LRU scan, sector address generation and output register.
// Depends on lbc_pkg and the assertion macro header; commanded by lbc_ctrl.
`include "lru_block_cache_controller_assert.svh"

module lbc_dpath #(
	parameter int NUM_SLOTS   = lbc_pkg::NUM_SLOTS_DEF,
	parameter int MAX_SECTORS = lbc_pkg::MAX_SECTORS_DEF,
	parameter int SLOT_W      = $clog2(NUM_SLOTS),
	parameter int OFF_W       = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
	parameter int IN_W        = ((lbc_pkg::BLK_W + 1 + 7) / 8) * 8,
	parameter int OUT_W       = ((SLOT_W + 2 + lbc_pkg::ADDR_W + OFF_W + 1 + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lbc_pkg::ctrl_cmd_t       cmd,
	output lbc_pkg::dp_status_t      sts,
	input  logic [1:0]               s_tuser,
	input  logic [IN_W-1:0]          s_tdata,
	input  logic                     cfg_valid,
	input  logic [lbc_pkg::SPB_W-1:0] cfg_data,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [2:0]               m_tuser,
	output logic [OUT_W-1:0]         m_tdata,
	output logic                     m_tlast
);

	localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
	localparam int PACK_W = SLOT_W + 2 + lbc_pkg::ADDR_W + OFF_W + 1;

	logic [lbc_pkg::SPB_W-1:0]   spb_q;
	lbc_pkg::action_t            act_q;
	logic [lbc_pkg::BLK_W-1:0]   key_q;
	logic                        err_q;

	logic [lbc_pkg::BLK_W-1:0]   tag_q   [NUM_SLOTS];
	logic [lbc_pkg::STAMP_W-1:0] stamp_q [NUM_SLOTS];
	logic [lbc_pkg::STAMP_W-1:0] use_cnt_q;
	lbc_pkg::pend_t              pend_kind_q;
	logic [SLOT_W-1:0]           pend_slot_q;
	logic [lbc_pkg::BLK_W-1:0]   pend_blk_q;

	logic [SLOT_W-1:0]           scan_idx_q;
	logic                        hit_q;
	logic [SLOT_W-1:0]           hit_idx_q;
	logic [lbc_pkg::STAMP_W-1:0] best_q;
	logic [SLOT_W-1:0]           vic_q;

	logic [lbc_pkg::ADDR_W-1:0]  lba_q;
	logic [OFF_W-1:0]            sec_q;

	logic                        m_tvalid_q;
	logic [2:0]                  m_tuser_q;
	logic [OUT_W-1:0]            m_tdata_q;
	logic                        m_tlast_q;

	logic [CNT_W-1:0]            n_cnt;
	logic [lbc_pkg::BLK_W-1:0]   scan_key;
	logic                        match;
	logic                        sec_last;
	logic                        out_free;
	logic [lbc_pkg::STAMP_W-1:0] use_cnt_inc;

	lbc_pkg::stat_t              o_stat;
	logic [SLOT_W-1:0]           o_slot;
	lbc_pkg::dcmd_t              o_cmd;
	logic [lbc_pkg::ADDR_W-1:0]  o_addr;
	logic [OFF_W-1:0]            o_off;
	logic                        o_refresh;
	logic                        o_last;
	logic [PACK_W-1:0]           o_pack;

	always_comb begin
		if (spb_q == '0) begin
			n_cnt = CNT_W'(1);
		end else if (int'(spb_q) > MAX_SECTORS) begin
			n_cnt = CNT_W'(MAX_SECTORS);
		end else begin
			n_cnt = CNT_W'(spb_q);
		end
	end

	assign scan_key    = (act_q == lbc_pkg::ACT_DONE) ? pend_blk_q : key_q;
	assign match       = (tag_q[scan_idx_q] == scan_key);
	assign sec_last    = ((CNT_W'(sec_q) + CNT_W'(1)) == n_cnt);
	assign out_free    = !m_tvalid_q || m_tready;
	assign use_cnt_inc = use_cnt_q + lbc_pkg::STAMP_W'(1);

	assign sts.act        = act_q;
	assign sts.blk_zero   = (key_q == '0);
	assign sts.io_err     = err_q;
	assign sts.pend       = pend_kind_q;
	assign sts.scan_last  = (scan_idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign sts.hit        = hit_q;
	assign sts.issue_last = sec_last;
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= lbc_pkg::SPB_RESET;
		end else if (cfg_valid) begin
			spb_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= lbc_pkg::action_t'(s_tuser);
			key_q <= s_tdata[lbc_pkg::BLK_W-1:0];
			err_q <= s_tdata[lbc_pkg::BLK_W];
		end
		if (cmd.scan_step && (scan_idx_q == '0 || stamp_q[scan_idx_q] < best_q)) begin
			best_q <= stamp_q[scan_idx_q];
			vic_q  <= scan_idx_q;
		end
		if (cmd.issue_read || cmd.issue_write) begin
			lba_q <= lbc_pkg::ADDR_W'(key_q * lbc_pkg::BLK_W'(n_cnt));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
		end else if (cmd.load) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tag_q[i]   <= '0;
				stamp_q[i] <= '0;
			end
			use_cnt_q   <= '0;
			pend_kind_q <= lbc_pkg::PEND_NONE;
			pend_slot_q <= '0;
			pend_blk_q  <= '0;
			sec_q       <= '0;
		end else begin
			if (cmd.issue_read) begin
				pend_kind_q <= lbc_pkg::PEND_READ;
				pend_slot_q <= vic_q;
				pend_blk_q  <= key_q;
				sec_q       <= '0;
			end
			if (cmd.issue_write) begin
				pend_kind_q <= lbc_pkg::PEND_WRITE;
				pend_slot_q <= '0;
				pend_blk_q  <= key_q;
				sec_q       <= '0;
			end
			if (cmd.emit) begin
				unique case (cmd.resp)
					lbc_pkg::RESP_HIT: begin
						use_cnt_q          <= use_cnt_inc;
						stamp_q[hit_idx_q] <= use_cnt_inc;
					end
					lbc_pkg::RESP_CMD: begin
						sec_q <= sec_q + OFF_W'(1);
					end
					lbc_pkg::RESP_FILLED: begin
						use_cnt_q            <= use_cnt_inc;
						tag_q[pend_slot_q]   <= pend_blk_q;
						stamp_q[pend_slot_q] <= use_cnt_inc;
						pend_kind_q          <= lbc_pkg::PEND_NONE;
					end
					lbc_pkg::RESP_ERR_READ: begin
						tag_q[pend_slot_q] <= '0;
						pend_kind_q        <= lbc_pkg::PEND_NONE;
					end
					lbc_pkg::RESP_ERR_WRITE: begin
						pend_kind_q <= lbc_pkg::PEND_NONE;
					end
					lbc_pkg::RESP_WRITTEN: begin
						pend_kind_q <= lbc_pkg::PEND_NONE;
					end
					lbc_pkg::RESP_FLUSHED: begin
						for (int i = 0; i < NUM_SLOTS; i++) begin
							tag_q[i] <= '0;
						end
						use_cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		o_stat    = lbc_pkg::STAT_BUSY;
		o_slot    = '0;
		o_cmd     = lbc_pkg::DCMD_NONE;
		o_addr    = '0;
		o_off     = '0;
		o_refresh = 1'b0;
		o_last    = 1'b1;
		unique case (cmd.resp)
			lbc_pkg::RESP_HIT: begin
				o_stat = lbc_pkg::STAT_HIT;
				o_slot = hit_idx_q;
			end
			lbc_pkg::RESP_CMD: begin
				o_stat = lbc_pkg::STAT_CMD;
				o_slot = pend_slot_q;
				o_cmd  = (pend_kind_q == lbc_pkg::PEND_READ) ? lbc_pkg::DCMD_READ
				                                             : lbc_pkg::DCMD_WRITE;
				o_addr = lba_q + lbc_pkg::ADDR_W'(sec_q);
				o_off  = sec_q;
				o_last = sec_last;
			end
			lbc_pkg::RESP_FILLED: begin
				o_stat = lbc_pkg::STAT_FILLED;
				o_slot = pend_slot_q;
			end
			lbc_pkg::RESP_ZERO: begin
				o_stat = lbc_pkg::STAT_ZERO;
			end
			lbc_pkg::RESP_ERR_READ: begin
				o_stat = lbc_pkg::STAT_IOERR;
				o_slot = pend_slot_q;
			end
			lbc_pkg::RESP_ERR_WRITE: begin
				o_stat = lbc_pkg::STAT_IOERR;
			end
			lbc_pkg::RESP_WRITTEN: begin
				o_stat    = lbc_pkg::STAT_WRITTEN;
				o_slot    = hit_q ? hit_idx_q : '0;
				o_refresh = hit_q;
			end
			lbc_pkg::RESP_FLUSHED: begin
				o_stat = lbc_pkg::STAT_FLUSHED;
			end
			default: begin
				o_stat = lbc_pkg::STAT_BUSY;
			end
		endcase
	end

	assign o_pack = {o_refresh, o_off, o_addr, o_cmd, o_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tuser_q <= o_stat;
			m_tdata_q <= OUT_W'(o_pack);
			m_tlast_q <= o_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`LBC_ASSERT_IMP(a_emit_needs_room, clk, arst_n, cmd.emit, out_free, "Result pushed into a full output register.")
	`LBC_ASSERT_NXT(a_fill_clears_pend, clk, arst_n, cmd.emit && cmd.resp == lbc_pkg::RESP_FILLED, pend_kind_q == lbc_pkg::PEND_NONE, "Pending transfer survived its fill.")
	`LBC_ASSERT_IMP(a_sector_in_range, clk, arst_n, cmd.emit && cmd.resp == lbc_pkg::RESP_CMD, CNT_W'(sec_q) < n_cnt, "Sector request beyond the block.")
	`LBC_ASSERT_IMP(a_fill_only_on_miss, clk, arst_n, cmd.issue_read, !hit_q, "Fill started for a cached block.")

endmodule

// ----- rtl/core/lru_block_cache_controller.sv -----
// Timing: a request is taken in S_IDLE and decoded in S_DECODE; a plain answer then goes
// through S_RESP into the output register once that is free. Reads and write completions
// scan the slot table, one slot per cycle, then choose in S_CHOOSE; a read miss then issues
// one sector request per cycle while the output is free. A new request is taken once the
// last result of the previous one is registered. Reset (arst_n low, asynchronous) empties
// all slots, clears stamps, counter and pending transfer, and sets sectors per block to two.
module lru_block_cache_controller #(
	parameter int NUM_SLOTS   = lbc_pkg::NUM_SLOTS_DEF,
	parameter int MAX_SECTORS = lbc_pkg::MAX_SECTORS_DEF,
	localparam int SLOT_W     = $clog2(NUM_SLOTS),
	localparam int OFF_W      = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
	localparam int IN_W       = ((lbc_pkg::BLK_W + 1 + 7) / 8) * 8,
	localparam int OUT_W      = ((SLOT_W + 2 + lbc_pkg::ADDR_W + OFF_W + 1 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_W-1:0]           s_tdata,   // block_number, io_error
	input  logic [1:0]                s_tuser,   // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_W-1:0]          m_tdata,   // slot, disk_command, sector_address,
	                                             // sector_offset, refresh_slot
	output logic [2:0]                m_tuser,   // status
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lbc_pkg::SPB_W-1:0] cfg_data
);

	lbc_pkg::ctrl_cmd_t  cmd;
	lbc_pkg::dp_status_t sts;

	assign cfg_ready = 1'b1;

	lbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbc_dpath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.MAX_SECTORS (MAX_SECTORS),
		.SLOT_W      (SLOT_W),
		.OFF_W       (OFF_W),
		.IN_W        (IN_W),
		.OUT_W       (OUT_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
